// ----- rtl/wmq_pkg.sv -----
// wmq_pkg: shared types and constants of the wildcard match queue
// holds request, result and cell layouts, status and command codes
// no dependencies
package wmq_pkg;

    localparam logic [15:0] ANY_FRAGMENT = 16'hFFFF;

    typedef enum logic [0:0] {
        CMD_ENQUEUE = 1'b0,
        CMD_RECEIVE = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_MATCHED  = 2'd0,
        ST_NOMATCH  = 2'd1,
        ST_ENQUEUED = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        FSM_IDLE = 1'b0,
        FSM_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic [31:0] sender;
        logic [31:0] inode;
        logic [15:0] ident;
        logic [15:0] fragment;
        logic        has_packet;
        logic [31:0] handle;
    } cell_t;

    typedef struct packed {
        cmd_t        command;
        logic [3:0]  port;
        logic [31:0] msg_source;
        logic [31:0] msg_inode;
        logic [15:0] msg_ident;
        logic [15:0] msg_fragment;
        logic        carries_packet;
        logic [31:0] packet_handle;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic        found_packet;
        logic [31:0] found_handle;
    } result_t;

endpackage

// ----- rtl/wmq_row_ram.sv -----
// wmq_row_ram: single-port-write, single-port-read synchronous row memory
// one row holds a whole queue and its fill; read data registered on rd_en
// no dependencies
module wmq_row_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/wmq_match.sv -----
// wmq_match: per-cell filter compare, first-match select, compaction and append
// works on one queue row read from wmq_row_ram
// depends on wmq_pkg
module wmq_match
    import wmq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int FILL_W = 5,
    parameter int IDX_W = 4
) (
    input  req_t                         req,
    input  logic                         port_ok,
    input  cell_t [QUEUE_DEPTH-1:0]      rd_cells,
    input  logic [FILL_W-1:0]            rd_fill,
    output cell_t [QUEUE_DEPTH-1:0]      wr_cells,
    output logic [FILL_W-1:0]            wr_fill,
    output logic                         wr_en,
    output result_t                      result
);

    logic [QUEUE_DEPTH-1:0] match;
    logic                   hit_found;
    logic [IDX_W-1:0]       hit_idx;
    logic                   queue_full;
    cell_t                  new_cell;
    cell_t                  hit_cell;

    always_comb
    begin
        for (int j = 0; j < QUEUE_DEPTH; j++)
        begin
            match[j] = (FILL_W'(j) < rd_fill);
            if (req.msg_source != 32'd0 && req.msg_source != rd_cells[j].sender)
            begin
                match[j] = 1'b0;
            end
            if (req.msg_inode != 32'd0 &&
                (!rd_cells[j].has_packet || req.msg_inode != rd_cells[j].inode))
            begin
                match[j] = 1'b0;
            end
            if (req.msg_ident != 16'd0 &&
                (!rd_cells[j].has_packet || req.msg_ident != rd_cells[j].ident))
            begin
                match[j] = 1'b0;
            end
            if (req.msg_fragment != ANY_FRAGMENT &&
                (!rd_cells[j].has_packet || req.msg_fragment != rd_cells[j].fragment))
            begin
                match[j] = 1'b0;
            end
        end
    end

    // oldest matching cell wins
    always_comb
    begin
        hit_found = 1'b0;
        hit_idx   = '0;
        for (int j = QUEUE_DEPTH - 1; j >= 0; j--)
        begin
            if (match[j])
            begin
                hit_found = 1'b1;
                hit_idx   = IDX_W'(j);
            end
        end
    end

    assign hit_cell   = rd_cells[hit_idx];
    assign queue_full = (32'(rd_fill) >= QUEUE_DEPTH);

    always_comb
    begin
        new_cell            = '0;
        new_cell.sender     = req.msg_source;
        new_cell.inode      = req.msg_inode;
        new_cell.ident      = req.msg_ident;
        new_cell.fragment   = req.msg_fragment;
        new_cell.has_packet = req.carries_packet;
        new_cell.handle     = req.carries_packet ? req.packet_handle : 32'd0;
    end

    always_comb
    begin
        wr_cells = rd_cells;
        wr_fill  = rd_fill;
        wr_en    = 1'b0;
        result   = '{status: ST_NOMATCH, found_packet: 1'b0, found_handle: 32'd0};
        unique case (req.command)
            CMD_ENQUEUE:
            begin
                if (!port_ok || queue_full)
                begin
                    result.status = ST_FULL;
                end
                else
                begin
                    for (int j = 0; j < QUEUE_DEPTH; j++)
                    begin
                        if (FILL_W'(j) == rd_fill)
                        begin
                            wr_cells[j] = new_cell;
                        end
                    end
                    wr_fill       = rd_fill + FILL_W'(1);
                    wr_en         = 1'b1;
                    result.status = ST_ENQUEUED;
                end
            end
            CMD_RECEIVE:
            begin
                if (port_ok && hit_found)
                begin
                    // shift younger cells down over the removed one
                    for (int j = 0; j < QUEUE_DEPTH - 1; j++)
                    begin
                        if (IDX_W'(j) >= hit_idx)
                        begin
                            wr_cells[j] = rd_cells[j + 1];
                        end
                    end
                    wr_fill             = rd_fill - FILL_W'(1);
                    wr_en               = 1'b1;
                    result.status       = ST_MATCHED;
                    result.found_packet = hit_cell.has_packet;
                    result.found_handle = hit_cell.has_packet ? hit_cell.handle : 32'd0;
                end
            end
            default:
            begin
                result.status = ST_NOMATCH;
            end
        endcase
    end

endmodule

// ----- rtl/wildcard_match_queue_recv.sv -----
// wildcard_match_queue_recv: per-port message queues with wildcard receive
// top level: request/result channels, control sequencer, valid bits per row
// depends on wmq_pkg, wmq_row_ram, wmq_match
//
// requests enter on the s_ channel: s_tuser carries the command (enqueue or
// receive), s_tdata the port and the message fields. one result per request
// leaves on the m_ channel: m_tuser carries the status, m_tdata the found
// packet mark and handle.
// each port's queue, with its fill count, is one row of a synchronous memory.
// the accept cycle reads the row; the next cycle compares all cells of the
// row at once and picks the oldest match; once the result register is free,
// it compacts or appends and writes the row back while loading the result
// register. the result is visible on m_tvalid the cycle after that. a new
// request is taken only once the last one has loaded its result, since the
// row read-modify-write must finish first.
// reset clears the control state and one valid bit per row, so every queue
// starts empty at once; no clearing pass is needed.
// while m_tready is low and a result is held, a finished request waits in
// the compute step and s_tready stays low until the result register frees.
module wildcard_match_queue_recv
    import wmq_pkg::*;
#(
    parameter int NUM_PORTS = 16,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // port[3:0], msg_source[35:4], msg_inode[67:36], msg_ident[83:68],
    // msg_fragment[99:84], carries_packet[100], packet_handle[132:101], zero fill
    input  logic [135:0] s_tdata,
    // command[0]
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // found_packet[0], found_handle[32:1], zero fill
    output logic [39:0]  m_tdata,
    // status[1:0]
    output logic [1:0]   m_tuser
);

    localparam int PORT_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CELLS_W = QUEUE_DEPTH * $bits(cell_t);
    localparam int ROW_W  = FILL_W + CELLS_W;

    state_t                  state_reg, state_next;
    req_t                    req_reg;
    req_t                    in_req;
    logic [PORT_W-1:0]       req_idx;
    logic                    port_ok;
    logic [NUM_PORTS-1:0]    row_valid_reg;
    logic                    out_valid_reg, out_valid_next;
    result_t                 out_result_reg;

    logic                    in_accept;
    logic                    load_result;
    logic [ROW_W-1:0]        rd_row;
    logic [ROW_W-1:0]        wr_row;
    cell_t [QUEUE_DEPTH-1:0] rd_cells;
    cell_t [QUEUE_DEPTH-1:0] wr_cells;
    logic [FILL_W-1:0]       rd_fill;
    logic [FILL_W-1:0]       wr_fill;
    logic                    match_wr_en;
    logic                    ram_wr_en;
    result_t                 match_result;

    assign in_req.command        = cmd_t'(s_tuser[0]);
    assign in_req.port           = s_tdata[3:0];
    assign in_req.msg_source     = s_tdata[35:4];
    assign in_req.msg_inode      = s_tdata[67:36];
    assign in_req.msg_ident      = s_tdata[83:68];
    assign in_req.msg_fragment   = s_tdata[99:84];
    assign in_req.carries_packet = s_tdata[100];
    assign in_req.packet_handle  = s_tdata[132:101];

    assign in_accept = s_tvalid && s_tready;
    assign req_idx   = PORT_W'(req_reg.port);
    assign port_ok   = (32'(req_reg.port) < NUM_PORTS);

    always_comb
    begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        load_result = 1'b0;
        unique case (state_reg)
            FSM_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    load_result = 1'b1;
                    state_next  = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_reg <= in_req;
        end
    end

    wmq_row_ram #(
        .WIDTH  (ROW_W),
        .DEPTH  (NUM_PORTS),
        .ADDR_W (PORT_W)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (req_idx),
        .wr_data (wr_row),
        .rd_en   (in_accept),
        .rd_addr (PORT_W'(in_req.port)),
        .rd_data (rd_row)
    );

    // a row never written reads as an empty queue
    assign rd_cells = rd_row[CELLS_W-1:0];
    assign rd_fill  = (port_ok && row_valid_reg[req_idx]) ? rd_row[ROW_W-1:CELLS_W]
                                                           : '0;
    assign wr_row   = {wr_fill, wr_cells};
    assign ram_wr_en = load_result && match_wr_en;

    wmq_match #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .FILL_W      (FILL_W),
        .IDX_W       (IDX_W)
    ) u_match (
        .req      (req_reg),
        .port_ok  (port_ok),
        .rd_cells (rd_cells),
        .rd_fill  (rd_fill),
        .wr_cells (wr_cells),
        .wr_fill  (wr_fill),
        .wr_en    (match_wr_en),
        .result   (match_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (ram_wr_en)
        begin
            row_valid_reg[req_idx] <= 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            out_result_reg <= match_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_result_reg.status;
    assign m_tdata  = {7'd0, out_result_reg.found_handle, out_result_reg.found_packet};

    // an accepted request always moves into the compute step
    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == FSM_EXEC)
        else $error("accepted request did not enter compute step");

    // row write-back only happens while finishing a request
    a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> state_reg == FSM_EXEC && port_ok)
        else $error("row written outside compute step");

    // fill count stays within the queue depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> 32'(wr_fill) <= QUEUE_DEPTH)
        else $error("queue fill beyond depth");

    // loading a result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_result |-> !out_valid_reg || m_tready)
        else $error("pending result overwritten");

    // only a removal carries packet fields
    a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ST_MATCHED |-> m_tdata[32:0] == 33'd0)
        else $error("found fields set without a match");

endmodule
